// ===== rtl/core/pngsd_pkg.sv =====
// shared types, constants and checksum helpers of the stored-deflate png encoder
`timescale 1ns / 1ps

package pngsd_pkg;

	localparam int DimW = 13;
	localparam int RawW = 27;
	localparam logic [DimW-1:0] MaxDimension = 13'd4096;
	localparam logic [15:0] StoredBlockMax = 16'd65535;
	localparam logic [16:0] AdlerMod = 17'd65521;
	localparam logic [31:0] CrcPoly = 32'hedb88320;
	localparam logic [31:0] CrcInit = 32'hffffffff;
	localparam logic [DimW-1:0] WidthReset = 13'd256;
	localparam logic [DimW-1:0] HeightReset = 13'd224;

	localparam logic CmdStart = 1'b0;
	localparam logic CmdPixel = 1'b1;

	localparam logic RegWidth = 1'b0;
	localparam logic RegHeight = 1'b1;

	typedef struct packed {
		logic        command;
		logic [23:0] pixel_rgb;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       end_of_image;
	} out_item_t;

	typedef struct packed {
		logic frame_active;
		logic busy;
	} back_status_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] x;
		x = c ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			x = (x >> 1) ^ (CrcPoly & {32{x[0]}});
		end
		return x;
	endfunction

	function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] d);
		if (d == '0) begin
			return 13'd1;
		end else if (d > MaxDimension) begin
			return MaxDimension;
		end
		return d;
	endfunction

	function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] s);
		logic [7:0] r;
		case (s)
			2'd0: r = w[31:24];
			2'd1: r = w[23:16];
			2'd2: r = w[15:8];
			default: r = w[7:0];
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/pngsd_queue.sv =====
// front: two-entry command queue between the input channel and the byte sequencer
`timescale 1ns / 1ps

module pngsd_queue
	import pngsd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	output logic     item_valid,
	output in_item_t item,
	input  logic     item_pop
);

	in_item_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	assign in_stall   = (count_q == 2'd2);
	assign push       = in_valid && !in_stall;
	assign item_valid = (count_q != 2'd0);
	assign item       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (item_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, item_pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/pngsd_back.sv =====
// back: byte sequencer with crc-32, adler-32 and stored block framing
`timescale 1ns / 1ps

module pngsd_back
	import pngsd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  in_item_t         item,
	output logic             item_pop,
	input  logic [DimW-1:0]  width,
	input  logic [DimW-1:0]  height,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data,
	output back_status_t     status
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_START = 4'b0010,
		ST_PIX   = 4'b0100,
		ST_TRAIL = 4'b1000
	} state_t;

	state_t          state_q;
	logic [5:0]      idx_q;
	logic [2:0]      rsel_q;
	logic [2:0]      hdr_q;
	logic [23:0]     rgb_q;
	logic            frame_q;
	logic [DimW-1:0] col_q;
	logic [DimW-1:0] row_q;
	logic [15:0]     blk_left_q;
	logic [RawW-1:0] raw_left_q;
	logic [RawW-1:0] raw_q;
	logic [15:0]     blocks_q;
	logic [31:0]     len_q;
	logic [15:0]     adl_lo_q;
	logic [15:0]     adl_hi_q;
	logic [31:0]     crc_q;
	logic [31:0]     hcrc_q;
	logic            out_valid_q;
	out_item_t       out_data_q;

	logic            can_emit;
	logic            fire;
	logic [7:0]      cur;
	logic            last;
	logic            eoi;
	logic            in_hdr;
	logic [15:0]     blk;
	logic [15:0]     inv;
	logic            final_blk;
	logic [7:0]      raw_byte;
	logic [DimW-1:0] col_inc;
	logic            wrap;
	logic [DimW-1:0] row_next;
	logic            pix_end;
	logic [16:0]     lo_s;
	logic [15:0]     lo_n;
	logic [16:0]     hi_s;
	logic [15:0]     hi_n;
	logic [27:0]     raw_prod;
	logic [16:0]     dsum;
	logic            dge;
	logic [16:0]     drem;
	logic [15:0]     blocks_n;
	logic [31:0]     len_n;
	logic [31:0]     wide_w;
	logic [31:0]     wide_h;

	assign can_emit = !out_valid_q || !out_stall;
	assign fire     = (state_q != ST_IDLE) && can_emit;
	assign item_pop = (state_q == ST_IDLE) && item_valid;

	assign wide_w   = {19'd0, width};
	assign wide_h   = {19'd0, height};
	assign raw_prod = ({2'b00, width, 2'b00} + 15'd1) * height;

	// ceil(raw / 65535) without a divider
	assign dsum     = {6'd0, raw_q[26:16]} + {1'b0, raw_q[15:0]};
	assign dge      = dsum >= {1'b0, StoredBlockMax};
	assign drem     = dge ? dsum - {1'b0, StoredBlockMax} : dsum;
	assign blocks_n = {5'd0, raw_q[26:16]} + {15'd0, dge} + {15'd0, (drem != 17'd0)};
	assign len_n    = 32'd6 + {5'd0, raw_q} + {14'd0, blocks_n, 2'b00} + {16'd0, blocks_q};

	assign blk       = (raw_left_q < {11'd0, StoredBlockMax}) ? raw_left_q[15:0] : StoredBlockMax;
	assign final_blk = ({11'd0, blk} == raw_left_q);
	assign inv       = ~blk;
	assign in_hdr    = (blk_left_q == 16'd0);

	assign col_inc  = col_q + 13'd1;
	assign wrap     = col_inc >= width;
	assign row_next = wrap ? row_q + 13'd1 : row_q;
	assign pix_end  = (row_next >= height) || (raw_left_q == 27'd1);

	assign lo_s = {1'b0, adl_lo_q} + {9'd0, raw_byte};
	assign lo_n = (lo_s >= AdlerMod) ? 16'(lo_s - AdlerMod) : lo_s[15:0];
	assign hi_s = {1'b0, adl_hi_q} + {1'b0, lo_n};
	assign hi_n = (hi_s >= AdlerMod) ? 16'(hi_s - AdlerMod) : hi_s[15:0];

	always_comb begin
		case (rsel_q)
			3'd0: raw_byte = 8'h00;
			3'd1: raw_byte = rgb_q[23:16];
			3'd2: raw_byte = rgb_q[15:8];
			3'd3: raw_byte = rgb_q[7:0];
			default: raw_byte = 8'hff;
		endcase
	end

	always_comb begin
		cur  = 8'h00;
		last = 1'b0;
		eoi  = 1'b0;
		case (state_q)
			ST_START: begin
				if (idx_q < 6'd8) begin
					case (idx_q[2:0])
						3'd0: cur = 8'h89;
						3'd1: cur = 8'h50;
						3'd2: cur = 8'h4e;
						3'd3: cur = 8'h47;
						3'd4: cur = 8'h0d;
						3'd5: cur = 8'h0a;
						3'd6: cur = 8'h1a;
						default: cur = 8'h0a;
					endcase
				end else if (idx_q < 6'd12) begin
					cur = be_byte(32'd13, 2'(idx_q - 6'd8));
				end else if (idx_q < 6'd16) begin
					cur = be_byte(32'h49484452, 2'(idx_q - 6'd12));
				end else if (idx_q < 6'd20) begin
					cur = be_byte(wide_w, 2'(idx_q - 6'd16));
				end else if (idx_q < 6'd24) begin
					cur = be_byte(wide_h, 2'(idx_q - 6'd20));
				end else if (idx_q == 6'd24) begin
					cur = 8'd8;
				end else if (idx_q == 6'd25) begin
					cur = 8'd6;
				end else if (idx_q < 6'd29) begin
					cur = 8'h00;
				end else if (idx_q < 6'd33) begin
					cur = be_byte(~hcrc_q, 2'(idx_q - 6'd29));
				end else if (idx_q < 6'd37) begin
					cur = be_byte(len_q, 2'(idx_q - 6'd33));
				end else if (idx_q < 6'd41) begin
					cur = be_byte(32'h49444154, 2'(idx_q - 6'd37));
				end else if (idx_q == 6'd41) begin
					cur = 8'h78;
				end else begin
					cur  = 8'h01;
					last = 1'b1;
				end
			end
			ST_PIX: begin
				if (in_hdr) begin
					case (hdr_q)
						3'd0: cur = {7'd0, final_blk};
						3'd1: cur = blk[7:0];
						3'd2: cur = blk[15:8];
						3'd3: cur = inv[7:0];
						default: cur = inv[15:8];
					endcase
				end else begin
					cur  = raw_byte;
					last = (rsel_q == 3'd4) && !pix_end;
				end
			end
			ST_TRAIL: begin
				if (idx_q < 6'd4) begin
					cur = be_byte({adl_hi_q, adl_lo_q}, idx_q[1:0]);
				end else if (idx_q < 6'd8) begin
					cur = be_byte(~crc_q, idx_q[1:0]);
				end else if (idx_q < 6'd12) begin
					cur = 8'h00;
				end else if (idx_q < 6'd16) begin
					cur = be_byte(32'h49454e44, idx_q[1:0]);
				end else begin
					cur  = be_byte(32'hae426082, idx_q[1:0]);
					last = (idx_q == 6'd19);
					eoi  = (idx_q == 6'd19);
				end
			end
			default: cur = 8'h00;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= '{out_byte: cur, last_of_run: last, end_of_image: eoi};
		end
		if (item_pop) begin
			rgb_q <= item.pixel_rgb;
			if (item.command == CmdStart) begin
				raw_q <= raw_prod[RawW-1:0];
			end
		end
		if (fire && state_q == ST_START) begin
			if (idx_q == 6'd1) begin
				blocks_q <= blocks_n;
			end
			if (idx_q == 6'd2) begin
				len_q <= len_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= 6'd0;
			rsel_q      <= 3'd0;
			hdr_q       <= 3'd0;
			frame_q     <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			blk_left_q  <= 16'd0;
			raw_left_q  <= '0;
			adl_lo_q    <= 16'd1;
			adl_hi_q    <= 16'd0;
			crc_q       <= CrcInit;
			hcrc_q      <= CrcInit;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_pop) begin
						if (item.command == CmdStart) begin
							state_q    <= ST_START;
							idx_q      <= 6'd0;
							frame_q    <= 1'b1;
							col_q      <= '0;
							row_q      <= '0;
							blk_left_q <= 16'd0;
							raw_left_q <= raw_prod[RawW-1:0];
							adl_lo_q   <= 16'd1;
							adl_hi_q   <= 16'd0;
							crc_q      <= CrcInit;
							hcrc_q     <= CrcInit;
						end else if (frame_q) begin
							state_q <= ST_PIX;
							rsel_q  <= (col_q == '0) ? 3'd0 : 3'd1;
							hdr_q   <= 3'd0;
						end
					end
				end
				ST_START: begin
					if (fire) begin
						if (idx_q >= 6'd12 && idx_q < 6'd29) begin
							hcrc_q <= crc_byte(hcrc_q, cur);
						end
						if (idx_q >= 6'd37) begin
							crc_q <= crc_byte(crc_q, cur);
						end
						if (last) begin
							state_q <= ST_IDLE;
							idx_q   <= 6'd0;
						end else begin
							idx_q <= idx_q + 6'd1;
						end
					end
				end
				ST_PIX: begin
					if (fire) begin
						crc_q <= crc_byte(crc_q, cur);
						if (in_hdr) begin
							if (hdr_q == 3'd4) begin
								blk_left_q <= blk;
								hdr_q      <= 3'd0;
							end else begin
								hdr_q <= hdr_q + 3'd1;
							end
						end else begin
							adl_lo_q   <= lo_n;
							adl_hi_q   <= hi_n;
							blk_left_q <= blk_left_q - 16'd1;
							raw_left_q <= raw_left_q - 27'd1;
							rsel_q     <= rsel_q + 3'd1;
							if (rsel_q == 3'd4) begin
								col_q <= wrap ? '0 : col_inc;
								row_q <= row_next;
								if (pix_end) begin
									state_q <= ST_TRAIL;
									idx_q   <= 6'd0;
								end else begin
									state_q <= ST_IDLE;
								end
							end
						end
					end
				end
				ST_TRAIL: begin
					if (fire) begin
						if (idx_q < 6'd4) begin
							crc_q <= crc_byte(crc_q, cur);
						end
						if (eoi) begin
							state_q    <= ST_IDLE;
							idx_q      <= 6'd0;
							frame_q    <= 1'b0;
							col_q      <= '0;
							row_q      <= '0;
							blk_left_q <= 16'd0;
							raw_left_q <= '0;
						end else begin
							idx_q <= idx_q + 6'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign status    = '{frame_active: frame_q, busy: (state_q != ST_IDLE)};

endmodule

// ===== rtl/core/png_stored_deflate_encoder.sv =====
// top level of the stored-deflate png encoder with its register port
// usage:
// in channel: one beat per command; command 0 starts an image and emits the
//   signature, IHDR, IDAT length and zlib header (43 bytes); command 1 carries
//   one RGB pixel and emits 4 to 10 bytes (filter byte, block header, RGBA),
//   plus 20 trailer bytes (adler-32, IDAT crc, IEND) on the last pixel
// out channel: one byte per beat; last_of_run marks the last byte of a command,
//   end_of_image the last byte of the file
// throughput: one byte per cycle through the single byte-wide output register while
//   out_stall does not hold it; the sequencer pops a command only while idle, so a
//   new command is taken only after every byte of the last one has been sequenced
// a command's first byte passes the queue, the sequencer state and the output register
// a two-beat queue decouples input from the sequencer; in_stall rises when full
// out_stall holds the output register and then the sequencer; nothing is lost
// pixels sent with no image open produce no bytes
// registers: width at 0x0, height at 0x4; writes while an image is open are
//   dropped; reads give the value as written, the encoder uses 0 as 1 and caps at 4096
// reset: no image open, size 256 x 224, queue empty
`timescale 1ns / 1ps

module png_stored_deflate_encoder
	import pngsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [DimW-1:0] width_q;
	logic [DimW-1:0] height_q;
	logic            cfg_wr;
	logic            item_valid;
	in_item_t        item;
	logic            item_pop;
	back_status_t    status;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == RegHeight) ? {19'd0, height_q} : {19'd0, width_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WidthReset;
			height_q <= HeightReset;
		end else if (cfg_wr && !status.frame_active) begin
			if (paddr[2] == RegWidth) begin
				width_q <= pwdata[DimW-1:0];
			end else begin
				height_q <= pwdata[DimW-1:0];
			end
		end
	end

	pngsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	pngsd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.width      (eff_dim(width_q)),
		.height     (eff_dim(height_q)),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.status     (status)
	);

	a_eoi_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.end_of_image |-> out_data.last_of_run)
		else $error("end of image without last of run");

	a_cfg_locked: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr && status.frame_active |=> $stable(width_q) && $stable(height_q))
		else $error("size changed while an image is open");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |-> item_valid && !status.busy)
		else $error("queue popped while sequencer busy");

endmodule
